>>> design/esm_pkg.sv
// Shared constants and types for the exact string match stream block.
package esm_pkg;

	// Longest pattern the window compare supports.
	localparam int MAX_PATTERN = 32;
	// Width of the per-text byte position counter.
	localparam int POSITION_BITS = 32;
	// Bytes held in the history window besides the newest byte.
	localparam int WIN_DEPTH = MAX_PATTERN - 1;
	// Bits for a pattern length minus one.
	localparam int LENM1_W = $clog2(MAX_PATTERN);

	// Fixed field widths of the configuration and result interfaces.
	localparam int PAT_WORDS = 4;
	localparam int WORD_W = 64;
	localparam int PAT_BYTES = PAT_WORDS * WORD_W / 8;
	localparam int PAT_IDX_W = $clog2(PAT_BYTES);
	localparam int CFG_LEN_W = 6;
	localparam int CFG_IDX_W = 3;
	localparam int COUNT_W = 16;
	localparam int OUT_POS_W = 32;
	localparam int IN_TDATA_W = 8;
	localparam int OUT_TDATA_W = 56;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PATTERN_0 = 3'd0,
		REG_PATTERN_1 = 3'd1,
		REG_PATTERN_2 = 3'd2,
		REG_PATTERN_3 = 3'd3,
		REG_LENGTH    = 3'd4,
		REG_LIMIT     = 3'd5
	} cfg_reg_t;

	// Pattern settings as the compare stage uses them: bytes already aligned
	// so that entry k is compared against the byte k places back in the text.
	typedef struct packed {
		logic [MAX_PATTERN-1:0][7:0] pat_aligned;
		logic [MAX_PATTERN-1:0]      care;
		logic [LENM1_W-1:0]          lenm1;
		logic                        len_zero;
		logic [COUNT_W-1:0]          limit;
	} cfg_t;

	// One input item.
	typedef struct packed {
		logic [7:0] text_byte;
		logic       last_byte;
	} in_item_t;

	// One result item.
	typedef struct packed {
		logic                 match_found;
		logic [OUT_POS_W-1:0] match_position;
		logic                 end_of_text;
		logic [COUNT_W-1:0]   match_total;
		logic                 limit_reached;
	} result_t;

endpackage

>>> design/esm_cfg.sv
// Configuration registers and pattern alignment for the string matcher.
module esm_cfg (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               wr_en,
	input  logic [esm_pkg::CFG_IDX_W-1:0]      wr_index,
	input  logic [esm_pkg::WORD_W-1:0]         wr_data,
	output esm_pkg::cfg_t                      cfg
);

	logic [esm_pkg::PAT_WORDS-1:0][esm_pkg::WORD_W-1:0] words_q, words_nxt;
	logic [esm_pkg::CFG_LEN_W-1:0]                      len_q, len_nxt;
	logic [esm_pkg::COUNT_W-1:0]                        limit_q, limit_nxt;
	logic [esm_pkg::PAT_BYTES-1:0][7:0]                 pat_bytes;
	logic [esm_pkg::LENM1_W:0]                          eff_len;
	logic [esm_pkg::LENM1_W-1:0]                        lenm1_nxt, lenm1_q;
	logic                                               zero_nxt, zero_q;
	logic [esm_pkg::MAX_PATTERN-1:0][7:0]               aligned_nxt, aligned_q;
	logic [esm_pkg::MAX_PATTERN-1:0]                    care_nxt, care_q;

	// Register values after the current write.
	always_comb begin
		words_nxt = words_q;
		len_nxt = len_q;
		limit_nxt = limit_q;
		if (wr_en) begin
			unique case (esm_pkg::cfg_reg_t'(wr_index))
				esm_pkg::REG_PATTERN_0: words_nxt[0] = wr_data;
				esm_pkg::REG_PATTERN_1: words_nxt[1] = wr_data;
				esm_pkg::REG_PATTERN_2: words_nxt[2] = wr_data;
				esm_pkg::REG_PATTERN_3: words_nxt[3] = wr_data;
				esm_pkg::REG_LENGTH:    len_nxt = wr_data[esm_pkg::CFG_LEN_W-1:0];
				esm_pkg::REG_LIMIT:     limit_nxt = wr_data[esm_pkg::COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Clamp the length and line the pattern up with the text window,
	// last pattern byte against the newest text byte.
	always_comb begin
		int i;
		pat_bytes = words_nxt;
		zero_nxt = (len_nxt == '0);
		if (int'(len_nxt) > esm_pkg::MAX_PATTERN) begin
			eff_len = (esm_pkg::LENM1_W + 1)'(esm_pkg::MAX_PATTERN);
		end else begin
			eff_len = (esm_pkg::LENM1_W + 1)'(len_nxt);
		end
		lenm1_nxt = esm_pkg::LENM1_W'(eff_len - 1'b1);
		for (int k = 0; k < esm_pkg::MAX_PATTERN; k++) begin
			i = int'(lenm1_nxt) - k;
			care_nxt[k] = !zero_nxt && (i >= 0);
			if (care_nxt[k] && (i < esm_pkg::PAT_BYTES)) begin
				aligned_nxt[k] = pat_bytes[esm_pkg::PAT_IDX_W'(i)];
			end else begin
				aligned_nxt[k] = 8'h00;
			end
		end
	end

	// Configuration storage; the derived form is refreshed on every write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			words_q <= '0;
			len_q <= esm_pkg::CFG_LEN_W'(1);
			limit_q <= '1;
			aligned_q <= '0;
			care_q <= esm_pkg::MAX_PATTERN'(1);
			lenm1_q <= '0;
			zero_q <= 1'b0;
		end else if (wr_en) begin
			words_q <= words_nxt;
			len_q <= len_nxt;
			limit_q <= limit_nxt;
			aligned_q <= aligned_nxt;
			care_q <= care_nxt;
			lenm1_q <= lenm1_nxt;
			zero_q <= zero_nxt;
		end
	end

	assign cfg.pat_aligned = aligned_q;
	assign cfg.care = care_q;
	assign cfg.lenm1 = lenm1_q;
	assign cfg.len_zero = zero_q;
	assign cfg.limit = limit_q;

endmodule

>>> design/esm_core.sv
// Window compare, per-text counters and result register of the string matcher.
module esm_core (
	input  logic              clk,
	input  logic              arst_n,
	input  esm_pkg::cfg_t     cfg,
	input  logic              in_valid,
	input  esm_pkg::in_item_t in_item,
	output logic              in_take,
	output logic              out_valid,
	input  logic              out_ready,
	output esm_pkg::result_t  out_result
);

	logic [esm_pkg::WIN_DEPTH-1:0][7:0]   win_q;
	logic [esm_pkg::POSITION_BITS-1:0]    pos_q;
	logic [esm_pkg::COUNT_W-1:0]          count_q, count_new;
	logic                                 out_valid_q;
	esm_pkg::result_t                     result_q;
	logic [esm_pkg::MAX_PATTERN-1:0][7:0] cur;
	logic [esm_pkg::MAX_PATTERN-1:0]      byte_ok;
	logic [esm_pkg::POSITION_BITS-1:0]    lenm1_ext, start;
	logic                                 pos_ok, hit, emit;

	// The result register is free when empty or being drained this cycle.
	assign in_take = in_valid && (!out_valid_q || out_ready);

	// Newest byte followed by the history, newest first.
	always_comb begin
		cur[0] = in_item.text_byte;
		for (int k = 1; k < esm_pkg::MAX_PATTERN; k++) begin
			cur[k] = win_q[k-1];
		end
		for (int k = 0; k < esm_pkg::MAX_PATTERN; k++) begin
			byte_ok[k] = !cfg.care[k] || (cfg.pat_aligned[k] == cur[k]);
		end
	end

	// Match decision, counter update and start offset.
	assign lenm1_ext = esm_pkg::POSITION_BITS'(cfg.lenm1);
	assign pos_ok = (pos_q >= lenm1_ext);
	assign hit = (&byte_ok) && !cfg.len_zero && pos_ok && (count_q < cfg.limit);
	assign count_new = hit ? count_q + 1'b1 : count_q;
	assign start = pos_q - lenm1_ext;
	assign emit = hit || in_item.last_byte;

	// History window; it needs no clearing since the position gates its use.
	always_ff @(posedge clk) begin
		if (in_take) begin
			win_q[0] <= in_item.text_byte;
			for (int k = 1; k < esm_pkg::WIN_DEPTH; k++) begin
				win_q[k] <= win_q[k-1];
			end
		end
	end

	// Per-text position and match count, cleared after the final byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			count_q <= '0;
		end else if (in_take) begin
			if (in_item.last_byte) begin
				pos_q <= '0;
				count_q <= '0;
			end else begin
				if (pos_q != '1) begin
					pos_q <= pos_q + 1'b1;
				end
				count_q <= count_new;
			end
		end
	end

	// Result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_take && emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (in_take && emit) begin
			result_q.match_found <= hit;
			result_q.match_position <= hit ? esm_pkg::OUT_POS_W'(start) : '0;
			result_q.end_of_text <= in_item.last_byte;
			result_q.match_total <= count_new;
			result_q.limit_reached <= (count_new >= cfg.limit);
		end
	end

	assign out_valid = out_valid_q;
	assign out_result = result_q;

endmodule

>>> design/exact_string_match_stream_top.sv
// Top level of the exact string match stream block.
// Text enters one byte per transfer; every start offset where the configured
// pattern (1 to 32 bytes) matches is reported in increasing order, overlapping
// matches included, until the per-text match limit is reached. The transfer
// that carries tlast always yields one result that ends the text and carries
// the running total. The block takes one byte every cycle while the result
// stream is ready: a byte lands in the input register at its transfer, the
// single compare stage (32 byte compares against the window plus the count
// check) decides on it as the core takes it from the input register, and the
// result is loaded into the output register, from which it transfers. A
// result that waits on a stalled result stream holds the byte behind it in
// the input register. Pattern writes take effect for the next byte.
module exact_string_match_stream_top (
	input  logic                               clk,
	input  logic                               arst_n,
	// Configuration write channel.
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [esm_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [esm_pkg::WORD_W-1:0]         cfg_data,
	// Text input stream.
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [esm_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // [7:0] text_byte
	input  logic                               s_axis_tlast,  // last_byte
	// Result stream.
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// [31:0] match_position, [47:32] match_total, [48] limit_reached, rest zero
	output logic [esm_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
	output logic                               m_axis_tuser,  // match_found
	output logic                               m_axis_tlast   // end_of_text
);

	esm_pkg::cfg_t     cfg;
	esm_pkg::in_item_t item_s1;
	esm_pkg::result_t  result;
	logic              valid_s1;
	logic              core_take;

	assign cfg_ready = 1'b1;

	esm_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// Input register; it refills in the same cycle that the core takes it.
	assign s_axis_tready = !valid_s1 || core_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			item_s1.text_byte <= s_axis_tdata[7:0];
			item_s1.last_byte <= s_axis_tlast;
		end
	end

	esm_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.in_valid   (valid_s1),
		.in_item    (item_s1),
		.in_take    (core_take),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_result (result)
	);

	// Pack the result onto the output stream.
	assign m_axis_tdata = {7'd0, result.limit_reached, result.match_total,
		result.match_position};
	assign m_axis_tuser = result.match_found;
	assign m_axis_tlast = result.end_of_text;

endmodule

>>> dv/esm_result_checker.sv
`timescale 1ns / 100ps
// Result checker for the exact string match stream block: predicts match reports and compares.
module esm_result_checker
	import esm_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	input  logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [WORD_W-1:0]      cfg_data,
	input  logic                   s_axis_tvalid,
	input  logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	input  logic                   s_axis_tlast,
	input  logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	input  logic [OUT_TDATA_W-1:0] m_axis_tdata,
	input  logic                   m_axis_tuser,
	input  logic                   m_axis_tlast,
	output int                     fail_count,
	output int                     reports_due
);

	localparam int SHOWN_ERRORS = 10;

	// Settings as last written through the configuration channel.
	logic [WORD_W-1:0]        pat_word [PAT_WORDS];
	logic [CFG_LEN_W-1:0]     pat_len;
	logic [COUNT_W-1:0]       hit_limit;

	// Per-text state: previous bytes (newest first), offset and reported matches.
	logic [7:0]               history [WIN_DEPTH];
	logic [POSITION_BITS-1:0] text_pos;
	logic [COUNT_W-1:0]       hit_count;

	// Match reports predicted but not yet seen on the result stream.
	result_t                  reports_expected [$];
	result_t                  seen;
	result_t                  want;
	int                       errors = 0;

	assign fail_count = errors;

	// Byte idx of the configured pattern; bytes past the four words read as zero.
	function automatic logic [7:0] pat_byte(input int idx);
		if (idx >= PAT_BYTES) begin
			return 8'h00;
		end
		return pat_word[idx / 8][(idx % 8) * 8 +: 8];
	endfunction

	// Forget everything about the current text.
	task automatic clear_text();
		int k;
		for (k = 0; k < WIN_DEPTH; k++) begin
			history[k] = 8'h00;
		end
		text_pos = '0;
		hit_count = '0;
	endtask

	// Settings after reset.
	task automatic reset_settings();
		int w;
		for (w = 0; w < PAT_WORDS; w++) begin
			pat_word[w] = '0;
		end
		pat_len = CFG_LEN_W'(1);
		hit_limit = '1;
	endtask

	// Record one register write.
	task automatic apply_write();
		case (cfg_reg_t'(cfg_index))
			REG_PATTERN_0, REG_PATTERN_1, REG_PATTERN_2, REG_PATTERN_3: begin
				pat_word[cfg_index[1:0]] = cfg_data;
			end
			REG_LENGTH: begin
				pat_len = cfg_data[CFG_LEN_W-1:0];
			end
			REG_LIMIT: begin
				hit_limit = cfg_data[COUNT_W-1:0];
			end
			default: begin
			end
		endcase
	endtask

	// Take one text byte: decide whether a match ends here and queue the report it causes.
	task automatic scan_byte(input logic [7:0] value, input logic is_last);
		int                       len;
		int                       k;
		bit                       hit;
		logic [POSITION_BITS-1:0] start;
		result_t                  r;
		len = int'(pat_len);
		if (len > MAX_PATTERN) begin
			len = MAX_PATTERN;
		end
		hit = 1'b0;
		start = '0;
		// Newest byte against the last pattern byte, the window against the rest.
		if (len >= 1 && text_pos >= POSITION_BITS'(len - 1)) begin
			hit = (pat_byte(len - 1) == value);
			for (k = 1; k < len; k++) begin
				if (pat_byte(len - 1 - k) != history[k - 1]) begin
					hit = 1'b0;
				end
			end
		end
		// Once the limit is reached, matches are no longer reported.
		if (hit && hit_count >= hit_limit) begin
			hit = 1'b0;
		end
		if (hit) begin
			start = text_pos - POSITION_BITS'(len - 1);
			hit_count = hit_count + 1'b1;
		end
		// Shift the window and advance the offset, which saturates.
		for (k = WIN_DEPTH - 1; k > 0; k--) begin
			history[k] = history[k - 1];
		end
		history[0] = value;
		if (text_pos != '1) begin
			text_pos = text_pos + 1'b1;
		end
		if (hit || is_last) begin
			r.match_found = hit;
			r.match_position = hit ? start[OUT_POS_W-1:0] : '0;
			r.end_of_text = is_last;
			r.match_total = hit_count;
			r.limit_reached = (hit_count >= hit_limit);
			reports_expected.push_back(r);
		end
		if (is_last) begin
			clear_text();
		end
	endtask

	// Compare one result transfer with the oldest predicted report.
	task automatic check_report();
		seen.match_found = m_axis_tuser;
		seen.match_position = m_axis_tdata[OUT_POS_W-1:0];
		seen.end_of_text = m_axis_tlast;
		seen.match_total = m_axis_tdata[OUT_POS_W +: COUNT_W];
		seen.limit_reached = m_axis_tdata[OUT_POS_W + COUNT_W];
		if (reports_expected.size() == 0) begin
			errors++;
			if (errors <= SHOWN_ERRORS) begin
				$display("%0t: unexpected result found=%0b pos=%0d eot=%0b total=%0d limit=%0b",
					$time, seen.match_found, seen.match_position, seen.end_of_text,
					seen.match_total, seen.limit_reached);
			end
		end else begin
			want = reports_expected.pop_front();
			if (seen.match_found !== want.match_found ||
				seen.match_position !== want.match_position ||
				seen.end_of_text !== want.end_of_text ||
				seen.match_total !== want.match_total ||
				seen.limit_reached !== want.limit_reached) begin
				errors++;
				if (errors <= SHOWN_ERRORS) begin
					$display("%0t: result mismatch", $time);
					$display("  expected found=%0b pos=%0d eot=%0b total=%0d limit=%0b",
						want.match_found, want.match_position, want.end_of_text,
						want.match_total, want.limit_reached);
					$display("  actual   found=%0b pos=%0d eot=%0b total=%0d limit=%0b",
						seen.match_found, seen.match_position, seen.end_of_text,
						seen.match_total, seen.limit_reached);
				end
			end
		end
	endtask

	// Watch all three channels; results are checked before new bytes are predicted.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reset_settings();
			clear_text();
			reports_expected.delete();
			reports_due <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				check_report();
			end
			if (cfg_valid && cfg_ready) begin
				apply_write();
			end
			if (s_axis_tvalid && s_axis_tready) begin
				scan_byte(s_axis_tdata, s_axis_tlast);
			end
			reports_due <= reports_expected.size();
		end
	end

endmodule

>>> dv/tb_exact_string_match_stream_top.sv
`timescale 1ns / 100ps
// Testbench top for the exact string match stream block: stimulus, settings and verdict.
module tb_exact_string_match_stream_top;
	import esm_pkg::*;

	localparam int RANDOM_ITEMS  = 1050;
	localparam int PHASES        = 12;
	localparam int PHASE_ITEMS   = RANDOM_ITEMS / PHASES;
	localparam int SETTLE_CYCLES = 4;
	localparam int DRAIN_CYCLES  = 10;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [WORD_W-1:0]      cfg_data = '0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;  // [7:0] text_byte
	logic                   s_axis_tlast = 1'b0; // last_byte
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	// [31:0] match_position, [47:32] match_total, [48] limit_reached
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic                   m_axis_tuser;        // match_found
	logic                   m_axis_tlast;        // end_of_text

	int                     fail_count;
	int                     reports_due;
	int                     gap_pct = 0;
	int                     stall_pct = 0;

	// Settings currently programmed into the block.
	logic [MAX_PATTERN-1:0][7:0] pat_now = '0;
	int                          len_now = 1;
	int                          limit_now = 65535;

	exact_string_match_stream_top DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	esm_result_checker u_result_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.fail_count    (fail_count),
		.reports_due   (reports_due)
	);

	// Clock generation.
	initial begin
		forever #4 clk = ~clk;
	end

	// Result receiver, stalling at the rate of the current phase.
	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= stall_pct);
	end

	// Send one text byte, with random idle cycles before it, and wait for its transfer.
	task automatic send_byte(input logic [7:0] value, input logic is_last);
		while ($urandom_range(99) < gap_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= value;
		s_axis_tlast <= is_last;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// Stop sending and let every pending result and the pipeline drain.
	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (reports_due != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// One register write transfer; valid is left high for back-to-back writes.
	task automatic write_reg(input cfg_reg_t idx, input logic [WORD_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// Program all registers from the current settings.
	task automatic write_settings();
		write_reg(REG_PATTERN_0, pat_now[7:0]);
		write_reg(REG_PATTERN_1, pat_now[15:8]);
		write_reg(REG_PATTERN_2, pat_now[23:16]);
		write_reg(REG_PATTERN_3, pat_now[31:24]);
		write_reg(REG_LENGTH, WORD_W'(len_now));
		write_reg(REG_LIMIT, WORD_W'(limit_now));
		cfg_valid <= 1'b0;
	endtask

	// Send a text of n bytes built from whole pattern copies, broken prefixes,
	// bytes of the pattern and arbitrary bytes.
	task automatic send_random_text(input int n);
		int         i;
		int         src;
		int         stop;
		int         r;
		logic [7:0] value;
		src = 0;
		stop = 0;
		r = 0;
		for (i = 0; i < n; i++) begin
			if (src >= stop) begin
				r = $urandom_range(99);
				src = 0;
				if (r < 40) begin
					stop = len_now;
				end else if (r < 55) begin
					stop = (len_now > 1) ? $urandom_range(1, len_now - 1) : 0;
				end else begin
					stop = 0;
				end
			end
			if (src < stop) begin
				value = pat_now[src];
				src++;
			end else if (r < 85) begin
				value = pat_now[$urandom_range(len_now - 1)];
			end else begin
				value = $urandom_range(255);
			end
			send_byte(value, i == n - 1);
		end
	endtask

	// Stimulus: reset, directed texts, then random phases under varying settings.
	initial begin
		int       ph;
		int       sent;
		int       n;
		int       i;
		bit       paused;
		bit       two_symbols;
		logic [7:0] sym_a;
		logic [7:0] sym_b;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: the pattern is a single zero byte.
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b1);
		// A one-byte text with no match.
		send_byte(8'hFF, 1'b1);
		wait_idle();

		// Two-byte pattern with a limit of one: the second match is suppressed.
		pat_now = '0;
		pat_now[0] = 8'h41;
		pat_now[1] = 8'h42;
		len_now = 2;
		limit_now = 1;
		write_settings();
		send_byte(8'h41, 1'b0);
		send_byte(8'h42, 1'b0);
		send_byte(8'h41, 1'b0);
		send_byte(8'h42, 1'b1);
		wait_idle();

		// Overlapping matches, the last one sharing the end-of-text result.
		pat_now[1] = 8'h41;
		limit_now = 65535;
		write_settings();
		send_byte(8'h41, 1'b0);
		send_byte(8'h41, 1'b0);
		send_byte(8'h41, 1'b1);
		wait_idle();

		// Limit lowered below the count in the middle of a text.
		len_now = 1;
		write_settings();
		send_byte(8'h41, 1'b0);
		send_byte(8'h41, 1'b0);
		wait_idle();
		limit_now = 1;
		write_settings();
		send_byte(8'h41, 1'b1);

		// Random phases, each with its own settings and idling pattern.
		for (ph = 0; ph < PHASES; ph++) begin
			wait_idle();
			case (ph % 4)
				0: begin
					gap_pct = 0;
					stall_pct = 0;
				end
				1: begin
					gap_pct = 49;
					stall_pct = 0;
				end
				2: begin
					gap_pct = 0;
					stall_pct = 49;
				end
				default: begin
					gap_pct = 8;
					stall_pct = 8;
				end
			endcase
			case (ph % 6)
				0: len_now = 1;
				1: len_now = MAX_PATTERN;
				2: len_now = 2;
				3: len_now = $urandom_range(3, 8);
				4: len_now = $urandom_range(9, MAX_PATTERN - 1);
				default: len_now = $urandom_range(1, MAX_PATTERN);
			endcase
			if (ph == 0) begin
				limit_now = 65535;
			end else if (ph == 1) begin
				limit_now = 1;
			end else begin
				case ($urandom_range(3))
					0: limit_now = 1;
					1: limit_now = 65535;
					2: limit_now = $urandom_range(2, 6);
					default: limit_now = $urandom_range(1, 65535);
				endcase
			end
			// A two-symbol pattern gives periodic text and many overlapping matches.
			two_symbols = $urandom_range(1);
			sym_a = $urandom_range(255);
			sym_b = $urandom_range(255);
			for (i = 0; i < MAX_PATTERN; i++) begin
				if (two_symbols) begin
					pat_now[i] = $urandom_range(1) ? sym_a : sym_b;
				end else begin
					pat_now[i] = $urandom_range(255);
				end
			end
			write_settings();

			sent = 0;
			paused = 1'b0;
			while (sent < PHASE_ITEMS) begin
				n = $urandom_range(1, 2 * len_now + 10);
				// The last text of a phase is cut so the phase sends its share exactly.
				if (n > PHASE_ITEMS - sent) begin
					n = PHASE_ITEMS - sent;
				end
				send_random_text(n);
				sent += n;
				// Hold off once per phase until the result stream has caught up.
				if (!paused && sent >= PHASE_ITEMS / 2) begin
					wait_idle();
					paused = 1'b1;
				end
			end
		end

		// Drain and give the verdict.
		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	// Run limit, far above the slowest correct run.
	initial begin
		#2000000;
		$display("Verification failed");
		$finish;
	end

endmodule
